### design/thc_pkg.sv
// Shared types, codes and helper functions for the heater control block.
package thc_pkg;

    localparam int TEMP_W = 16;
    localparam int SUM_W  = TEMP_W + 2;

    // item modes
    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_REQUEST = 2'd1;
    localparam logic [1:0] MODE_IGNORE  = 2'd2;

    // target states
    localparam logic [1:0] TARGET_NONOP  = 2'd0;
    localparam logic [1:0] TARGET_OP     = 2'd1;
    localparam logic [1:0] TARGET_HEAT   = 2'd2;
    localparam logic [1:0] TARGET_IGNORE = 2'd3;

    // component status
    localparam logic [2:0] STATUS_UNKNOWN  = 3'd0;
    localparam logic [2:0] STATUS_LOW      = 3'd1;
    localparam logic [2:0] STATUS_OP       = 3'd2;
    localparam logic [2:0] STATUS_HIGH     = 3'd3;
    localparam logic [2:0] STATUS_LOW_IGN  = 3'd4;
    localparam logic [2:0] STATUS_OP_IGN   = 3'd5;
    localparam logic [2:0] STATUS_HIGH_IGN = 3'd6;

    // heater commands
    localparam logic [1:0] CMD_DONT_CARE = 2'd0;
    localparam logic [1:0] CMD_ON        = 2'd1;
    localparam logic [1:0] CMD_OFF       = 2'd2;

    // request results
    localparam logic [1:0] REQ_OK      = 2'd0;
    localparam logic [1:0] REQ_REFUSED = 2'd1;
    localparam logic [1:0] REQ_INVALID = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_LOWER_OP_LIMIT   = 3'd0;
    localparam logic [2:0] REG_UPPER_OP_LIMIT   = 3'd1;
    localparam logic [2:0] REG_HEATER_ON_MARGIN = 3'd2;
    localparam logic [2:0] REG_HYSTERESIS_BAND  = 3'd3;
    localparam logic [2:0] REG_SWITCHOFF_MARGIN = 3'd4;
    localparam logic [2:0] REG_INITIAL_TARGET   = 3'd5;

    localparam logic signed [TEMP_W-1:0] LOWER_OP_LIMIT_RST   = -16'sd320;
    localparam logic signed [TEMP_W-1:0] UPPER_OP_LIMIT_RST   = 16'sd960;
    localparam logic signed [TEMP_W-1:0] HEATER_ON_MARGIN_RST = 16'sd32;
    localparam logic signed [TEMP_W-1:0] HYSTERESIS_BAND_RST  = 16'sd16;
    localparam logic signed [TEMP_W-1:0] SWITCHOFF_MARGIN_RST = 16'sd32;
    localparam logic [1:0]               INITIAL_TARGET_RST   = TARGET_OP;

    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sh7FFF;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [TEMP_W-1:0] lower_op_limit;
        logic signed [TEMP_W-1:0] upper_op_limit;
        logic signed [TEMP_W-1:0] heater_on_margin;
        logic signed [TEMP_W-1:0] hysteresis_band;
        logic signed [TEMP_W-1:0] switchoff_margin;
    } cfg_t;

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [TEMP_W-1:0] primary_temperature;
        logic                     primary_ok;
        logic signed [TEMP_W-1:0] redundant_one_temperature;
        logic                     redundant_one_ok;
        logic signed [TEMP_W-1:0] redundant_two_temperature;
        logic                     redundant_two_ok;
        logic signed [TEMP_W-1:0] module_temperature;
        logic                     module_ok;
        logic [1:0]               requested_state;
    } item_t;

    typedef struct packed {
        logic [1:0]               target;
        logic                     heating;
        logic [2:0]               status;
        logic signed [TEMP_W-1:0] temp;
        logic                     temp_valid;
        logic [1:0]               command;
        logic signed [TEMP_W-1:0] min_temp;
        logic signed [TEMP_W-1:0] max_temp;
    } state_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] chosen_temperature;
        logic                     chosen_valid;
        logic [2:0]               component_status;
        logic [1:0]               heater_command;
        logic signed [TEMP_W-1:0] lowest_seen;
        logic signed [TEMP_W-1:0] highest_seen;
        logic [1:0]               request_result;
        logic [1:0]               current_target;
    } result_t;

    function automatic logic [2:0] ignored_of(input logic [2:0] s);
        logic [2:0] r;
        case (s) inside
            STATUS_LOW:                                    r = STATUS_LOW_IGN;
            STATUS_OP:                                     r = STATUS_OP_IGN;
            STATUS_HIGH:                                   r = STATUS_HIGH_IGN;
            STATUS_LOW_IGN, STATUS_OP_IGN, STATUS_HIGH_IGN: r = s;
            default:                                       r = STATUS_UNKNOWN;
        endcase
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] widen(input logic signed [TEMP_W-1:0] v);
        return {{(SUM_W-TEMP_W){v[TEMP_W-1]}}, v};
    endfunction

endpackage

### design/thc_cfg_regs.sv
// Configuration register file holding the temperature limits and margins.
module thc_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output thc_pkg::cfg_t       cfg
);

    thc_pkg::cfg_t cfg_reg;
    thc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                thc_pkg::REG_LOWER_OP_LIMIT:   cfg_next.lower_op_limit   = cfg_data;
                thc_pkg::REG_UPPER_OP_LIMIT:   cfg_next.upper_op_limit   = cfg_data;
                thc_pkg::REG_HEATER_ON_MARGIN: cfg_next.heater_on_margin = cfg_data;
                thc_pkg::REG_HYSTERESIS_BAND:  cfg_next.hysteresis_band  = cfg_data;
                thc_pkg::REG_SWITCHOFF_MARGIN: cfg_next.switchoff_margin = cfg_data;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lower_op_limit   <= thc_pkg::LOWER_OP_LIMIT_RST;
            cfg_reg.upper_op_limit   <= thc_pkg::UPPER_OP_LIMIT_RST;
            cfg_reg.heater_on_margin <= thc_pkg::HEATER_ON_MARGIN_RST;
            cfg_reg.hysteresis_band  <= thc_pkg::HYSTERESIS_BAND_RST;
            cfg_reg.switchoff_margin <= thc_pkg::SWITCHOFF_MARGIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### design/thc_update.sv
// Per-word evaluation: sensor select, min/max, classification, heater command, requests, ignore.
module thc_update (
    input  thc_pkg::item_t   item,
    input  thc_pkg::state_t  state,
    input  thc_pkg::cfg_t    cfg,
    output thc_pkg::state_t  state_next,
    output thc_pkg::result_t result
);

    logic                                 found;
    logic signed [thc_pkg::TEMP_W-1:0]    t;
    logic signed [thc_pkg::SUM_W-1:0]     t_wide;
    logic signed [thc_pkg::SUM_W-1:0]     on_limit;
    logic signed [thc_pkg::SUM_W-1:0]     off_limit;
    logic [2:0]                           st;
    logic [1:0]                           req_result;

    // priority select: primary, redundant one, redundant two, module
    always_comb
    begin
        found = 1'b1;
        if (item.primary_ok)
            t = item.primary_temperature;
        else if (item.redundant_one_ok)
            t = item.redundant_one_temperature;
        else if (item.redundant_two_ok)
            t = item.redundant_two_temperature;
        else if (item.module_ok)
            t = item.module_temperature;
        else
        begin
            t = item.module_temperature;
            found = 1'b0;
        end
    end

    // thresholds are formed at full width, no saturation
    always_comb
    begin
        t_wide    = thc_pkg::widen(t);
        off_limit = thc_pkg::widen(cfg.upper_op_limit) - thc_pkg::widen(cfg.switchoff_margin);
        on_limit  = thc_pkg::widen(cfg.lower_op_limit) + thc_pkg::widen(cfg.heater_on_margin);
        if (state.heating)
            on_limit = on_limit + thc_pkg::widen(cfg.hysteresis_band);
    end

    always_comb
    begin
        if (t < cfg.lower_op_limit)
            st = thc_pkg::STATUS_LOW;
        else if (t < cfg.upper_op_limit)
            st = thc_pkg::STATUS_OP;
        else
            st = thc_pkg::STATUS_HIGH;
    end

    always_comb
    begin
        if (state.target == thc_pkg::TARGET_OP && item.requested_state != thc_pkg::TARGET_IGNORE)
            req_result = thc_pkg::REQ_REFUSED;
        else if (item.requested_state == thc_pkg::TARGET_NONOP)
            req_result = thc_pkg::REQ_INVALID;
        else
            req_result = thc_pkg::REQ_OK;
    end

    always_comb
    begin
        state_next = state;
        result.request_result = thc_pkg::REQ_OK;
        unique case (item.mode)
            thc_pkg::MODE_TICK:
            begin
                if (!found)
                begin
                    state_next.temp_valid = 1'b0;
                    state_next.status     = thc_pkg::STATUS_UNKNOWN;
                    state_next.command    = thc_pkg::CMD_DONT_CARE;
                end
                else
                begin
                    state_next.temp       = t;
                    state_next.temp_valid = 1'b1;
                    if (t < state.min_temp)
                        state_next.min_temp = t;
                    if (t > state.max_temp)
                        state_next.max_temp = t;
                    if (state.target == thc_pkg::TARGET_IGNORE)
                    begin
                        state_next.status  = thc_pkg::ignored_of(st);
                        state_next.heating = 1'b0;
                        state_next.command = thc_pkg::CMD_DONT_CARE;
                    end
                    else
                    begin
                        state_next.status = st;
                        if (t_wide > off_limit)
                        begin
                            state_next.heating = 1'b0;
                            state_next.command = thc_pkg::CMD_OFF;
                        end
                        else if (t_wide < on_limit)
                        begin
                            state_next.heating = 1'b1;
                            state_next.command = thc_pkg::CMD_ON;
                        end
                        else
                        begin
                            state_next.heating = 1'b0;
                            state_next.command = thc_pkg::CMD_DONT_CARE;
                        end
                    end
                end
            end
            thc_pkg::MODE_REQUEST:
            begin
                result.request_result = req_result;
                if (req_result == thc_pkg::REQ_OK)
                    state_next.target = item.requested_state;
            end
            thc_pkg::MODE_IGNORE:
            begin
                state_next.status = thc_pkg::ignored_of(state.status);
            end
            default:
            begin
                state_next = state;
            end
        endcase

        result.chosen_temperature = state_next.temp;
        result.chosen_valid       = state_next.temp_valid;
        result.component_status   = state_next.status;
        result.heater_command     = state_next.command;
        result.lowest_seen        = state_next.min_temp;
        result.highest_seen       = state_next.max_temp;
        result.current_target     = state_next.target;
    end

endmodule

### design/thermal_component_heater_control.sv
// Top level of the heater control block: input register, state, result register.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word per item: a mode,
//   four sensor readings with their ok bits and a requested target state.
//   Output channel (out_valid / out_stall) returns exactly one result word per
//   input word, in order.
//   Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
//   the limits and margins; cfg_ready is always high. Writing initial_target
//   loads the stored target state at once. Write only while the block is idle.
//   A word accepted on the input is registered, evaluated in one pass of
//   logic and shown on the output once the result register is free.
//   Throughput: one word per cycle while out_stall is low; the single
//   evaluation stage that updates the controller state sets this figure.
//   When out_stall is high with a result shown, the result register holds;
//   an empty input register still takes one more word, then in_stall rises.
//   Reset sets the controller state to its defaults: target operational, status
//   unknown, lowest seen at the positive limit, highest seen at the negative.
module thermal_component_heater_control (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic signed [15:0] primary_temperature,
    input  logic               primary_ok,
    input  logic signed [15:0] redundant_one_temperature,
    input  logic               redundant_one_ok,
    input  logic signed [15:0] redundant_two_temperature,
    input  logic               redundant_two_ok,
    input  logic signed [15:0] module_temperature,
    input  logic               module_ok,
    input  logic [1:0]         requested_state,

    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] chosen_temperature,
    output logic               chosen_valid,
    output logic [2:0]         component_status,
    output logic [1:0]         heater_command,
    output logic signed [15:0] lowest_seen,
    output logic signed [15:0] highest_seen,
    output logic [1:0]         request_result,
    output logic [1:0]         current_target,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    thc_pkg::cfg_t    cfg;
    thc_pkg::item_t   item_reg;
    thc_pkg::item_t   item_next;
    logic             item_valid_reg;
    logic             item_valid_next;
    thc_pkg::state_t  state_reg;
    thc_pkg::state_t  state_next;
    thc_pkg::state_t  state_upd;
    thc_pkg::result_t result_reg;
    thc_pkg::result_t result_next;
    thc_pkg::result_t result_upd;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             result_free;
    logic             in_accept;
    logic             cfg_write;
    logic             target_load;

    assign cfg_ready   = 1'b1;
    assign cfg_write   = cfg_valid && cfg_ready;
    assign target_load = cfg_write && (cfg_index == thc_pkg::REG_INITIAL_TARGET);

    thc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    thc_update u_update (
        .item       (item_reg),
        .state      (state_reg),
        .cfg        (cfg),
        .state_next (state_upd),
        .result     (result_upd)
    );

    assign result_free = !out_valid_reg || !out_stall;
    assign in_stall    = item_valid_reg && !result_free;
    assign in_accept   = in_valid && !in_stall;

    always_comb
    begin
        item_next       = item_reg;
        // hold a waiting word while the result register is blocked
        item_valid_next = in_accept || (item_valid_reg && !result_free);
        state_next      = state_reg;
        result_next     = result_reg;
        out_valid_next  = out_valid_reg;

        if (in_accept)
        begin
            item_next.mode                      = mode;
            item_next.primary_temperature       = primary_temperature;
            item_next.primary_ok                = primary_ok;
            item_next.redundant_one_temperature = redundant_one_temperature;
            item_next.redundant_one_ok          = redundant_one_ok;
            item_next.redundant_two_temperature = redundant_two_temperature;
            item_next.redundant_two_ok          = redundant_two_ok;
            item_next.module_temperature        = module_temperature;
            item_next.module_ok                 = module_ok;
            item_next.requested_state           = requested_state;
        end

        // advance the evaluation stage whenever the result register is free
        if (result_free)
        begin
            out_valid_next  = item_valid_reg;
            if (item_valid_reg)
            begin
                state_next  = state_upd;
                result_next = result_upd;
            end
        end

        if (target_load)
            state_next.target = cfg_data[1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg       <= 1'b0;
            out_valid_reg        <= 1'b0;
            state_reg.target     <= thc_pkg::INITIAL_TARGET_RST;
            state_reg.heating    <= 1'b0;
            state_reg.status     <= thc_pkg::STATUS_UNKNOWN;
            state_reg.temp       <= '0;
            state_reg.temp_valid <= 1'b0;
            state_reg.command    <= thc_pkg::CMD_DONT_CARE;
            state_reg.min_temp   <= thc_pkg::TEMP_MAX;
            state_reg.max_temp   <= thc_pkg::TEMP_MIN;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
            state_reg      <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    assign out_valid          = out_valid_reg;
    assign chosen_temperature = result_reg.chosen_temperature;
    assign chosen_valid       = result_reg.chosen_valid;
    assign component_status   = result_reg.component_status;
    assign heater_command     = result_reg.heater_command;
    assign lowest_seen        = result_reg.lowest_seen;
    assign highest_seen       = result_reg.highest_seen;
    assign request_result     = result_reg.request_result;
    assign current_target     = result_reg.current_target;

endmodule
